[rtl/four_neighbor_blur_filter_assert.svh]
// Assertion macros shared by the blur filter RTL.
`ifndef FOUR_NEIGHBOR_BLUR_FILTER_ASSERT_SVH
`define FOUR_NEIGHBOR_BLUR_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FNB_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FNB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/fnblur_pkg.sv]
`timescale 1ns / 1ps
package fnblur_pkg;

	localparam int PIX_W      = 32;
	localparam int IDX_W      = 22;
	localparam int POS_W      = 23;
	localparam int DIM_W      = 12;
	localparam int BLUR_W     = 9;
	localparam int TOTAL_W    = 24;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CHAN_W     = 8;
	localparam int OUT_DATA_W = 48;

	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_FRAME_WIDTH   = 2'd0;
	localparam cfg_idx_t CFG_FRAME_HEIGHT  = 2'd1;
	localparam cfg_idx_t CFG_BLUR_DISTANCE = 2'd2;

endpackage

[rtl/four_neighbor_blur_filter.sv]
`timescale 1ns / 1ps
// Channel    Direction  Payload (lowest bits first)
// s_axis     in         tdata: pixel_word[31:0]; tuser: frame_start
// m_axis     out        tdata: pixel_index[21:0], red_out, green_out, blue_out, 2 zero bits
// cfg        in         cfg_we, cfg_index (0 width, 1 height, 2 blur), cfg_data[11:0]
//
// One pixel is accepted per cycle unless the output stalls; the pixel completing a neighborhood
// (p + max(W, (B+2)/4)) loads the read stage for pixel p, then the output register.
// The six neighbor reads come from three copies of the delay line, each with two read ports.
// No clearing pass follows reset: an entry is only read after this frame has written it.
// A stalled output holds one result in the output register and one in the read stage.
`include "four_neighbor_blur_filter_assert.svh"
module four_neighbor_blur_filter #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	parameter int MAX_BLUR   = 400
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// pixel_word[31:0]
	input  logic [fnblur_pkg::PIX_W-1:0]         s_axis_tdata,
	// frame_start
	input  logic [0:0]                           s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// pixel_index[21:0], red_out[29:22], green_out[37:30], blue_out[45:38], zero[47:46]
	output logic [fnblur_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                                 cfg_we,
	input  fnblur_pkg::cfg_idx_t                 cfg_index,
	input  logic [fnblur_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int HIST = 2 * MAX_WIDTH + 2 * (MAX_BLUR / 4 + 1);
	localparam int AW   = $clog2(HIST);
	localparam int NRD  = 6;

	// Read ports: pixel above, below, and the two pixel pairs left and right.
	localparam int RD_UP = 0;
	localparam int RD_DN = 1;
	localparam int RD_L1 = 2;
	localparam int RD_L0 = 3;
	localparam int RD_R0 = 4;
	localparam int RD_R1 = 5;

	localparam logic [fnblur_pkg::DIM_W-1:0] W_RST =
		(fnblur_pkg::RST_WIDTH > MAX_WIDTH) ? 12'(MAX_WIDTH) : 12'(fnblur_pkg::RST_WIDTH);
	localparam logic [fnblur_pkg::DIM_W-1:0] H_RST =
		(fnblur_pkg::RST_HEIGHT > MAX_HEIGHT) ? 12'(MAX_HEIGHT) : 12'(fnblur_pkg::RST_HEIGHT);
	localparam logic [fnblur_pkg::TOTAL_W-1:0] TOTAL_RST = 24'(int'(W_RST) * int'(H_RST));

	typedef struct packed {
		logic [11:0]               lat;
		logic [6:0]                k;
		logic [7:0]                k1;
		logic [1:0]                r;
		logic [12:0]               two_w;
		logic                      h4_ok;
		logic [NRD-1:0]            zero;
		logic [NRD-1:0][AW-1:0]    lag;
	} geom_t;

	function automatic logic [11:0] clamp_dim(input logic [11:0] v, input int maxv);
		logic [11:0] res;
		if (v == '0) begin
			res = 12'd1;
		end else if (int'(v) > maxv) begin
			res = 12'(maxv);
		end else begin
			res = v;
		end
		return res;
	endfunction

	function automatic logic [8:0] clamp_blur(input logic [8:0] v);
		logic [8:0] res;
		if (int'(v) > MAX_BLUR) begin
			res = 9'(MAX_BLUR);
		end else begin
			res = v;
		end
		return res;
	endfunction

	function automatic geom_t derive(input logic [11:0] w, input logic [8:0] b);
		geom_t                  g;
		logic [7:0]             lb;
		logic [13:0]            lat14;
		logic [13:0]            k14;
		logic [13:0]            w14;
		logic [NRD-1:0][13:0]   d14;
		lb      = 8'(({1'b0, b} + 10'd2) >> 2);
		g.k     = b[8:2];
		g.k1    = {1'b0, b[8:2]} + 8'd1;
		g.r     = b[1:0];
		g.lat   = (w > {4'd0, lb}) ? w : {4'd0, lb};
		g.two_w = {w, 1'b0};
		g.h4_ok = g.lat > {5'd0, g.k};
		lat14   = {2'd0, g.lat};
		k14     = {7'd0, g.k};
		w14     = {2'd0, w};
		d14[RD_UP] = lat14 + w14;
		d14[RD_DN] = lat14 - w14;
		d14[RD_L1] = lat14 + k14 + 14'd1;
		d14[RD_L0] = lat14 + k14;
		d14[RD_R0] = lat14 - k14;
		d14[RD_R1] = lat14 - k14 - 14'd1;
		for (int i = 0; i < NRD; i++) begin
			g.lag[i]  = AW'(d14[i]);
			g.zero[i] = (d14[i] == 14'd0);
		end
		return g;
	endfunction

	// Configuration
	logic [fnblur_pkg::DIM_W-1:0]   w_q;
	logic [fnblur_pkg::DIM_W-1:0]   h_q;
	logic [fnblur_pkg::BLUR_W-1:0]  b_q;
	logic [fnblur_pkg::TOTAL_W-1:0] total_q;
	geom_t                          geo_q;
	logic [fnblur_pkg::DIM_W-1:0]   w_new;
	logic [fnblur_pkg::DIM_W-1:0]   h_new;
	logic [fnblur_pkg::BLUR_W-1:0]  b_new;

	assign w_new = clamp_dim(cfg_data, MAX_WIDTH);
	assign h_new = clamp_dim(cfg_data, MAX_HEIGHT);
	assign b_new = clamp_blur(cfg_data[8:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= W_RST;
			h_q     <= H_RST;
			b_q     <= '0;
			total_q <= TOTAL_RST;
			geo_q   <= derive(W_RST, 9'd0);
		end else if (cfg_we) begin
			unique case (cfg_index)
				fnblur_pkg::CFG_FRAME_WIDTH: begin
					w_q     <= w_new;
					total_q <= 24'(w_new) * 24'(h_q);
					geo_q   <= derive(w_new, b_q);
				end
				fnblur_pkg::CFG_FRAME_HEIGHT: begin
					h_q     <= h_new;
					total_q <= 24'(w_q) * 24'(h_new);
				end
				fnblur_pkg::CFG_BLUR_DISTANCE: begin
					b_q   <= b_new;
					geo_q <= derive(w_q, b_new);
				end
				default: begin
				end
			endcase
		end
	end

	// Accept stage
	logic                          item_acc;
	logic [fnblur_pkg::POS_W-1:0]  pos_q;
	logic [AW-1:0]                 wslot_q;
	logic [fnblur_pkg::POS_W-1:0]  q;
	logic                          live;
	logic [AW-1:0]                 cur_slot;
	logic [AW-1:0]                 next_slot;
	logic [fnblur_pkg::POS_W-1:0]  p23;
	logic [fnblur_pkg::IDX_W-1:0]  p;
	logic                          emit;
	logic [NRD-1:0]                nz;
	logic [NRD-1:0][AW-1:0]        rd_slot;
	logic                          wr_en;
	logic                          rd_en;
	logic                          v_s1;
	logic                          can_out;
	logic                          m_valid_q;

	assign item_acc  = s_axis_tvalid && s_axis_tready;
	assign q         = s_axis_tuser[0] ? '0 : pos_q;
	assign live      = !q[fnblur_pkg::POS_W-1];
	assign cur_slot  = s_axis_tuser[0] ? '0 : wslot_q;
	assign next_slot = (cur_slot == AW'(HIST - 1)) ? '0 : cur_slot + 1'b1;
	assign p23       = q - {11'd0, geo_q.lat};
	assign p         = p23[fnblur_pkg::IDX_W-1:0];

	assign emit = live && (q >= {11'd0, geo_q.lat})
		&& ({1'b0, p} >= {10'd0, geo_q.two_w})
		&& (({2'd0, p} + {11'd0, geo_q.two_w} + 24'd1) <= total_q);

	assign nz[RD_UP] = 1'b1;
	assign nz[RD_DN] = 1'b1;
	assign nz[RD_L1] = {1'b0, p} >= {15'd0, geo_q.k1};
	assign nz[RD_L0] = p >= {15'd0, geo_q.k};
	assign nz[RD_R0] = ({2'd0, p} + {17'd0, geo_q.k}) < total_q;
	assign nz[RD_R1] = geo_q.h4_ok && (({2'd0, p} + {16'd0, geo_q.k1}) < total_q);

	always_comb begin
		logic [AW:0] diff;
		for (int i = 0; i < NRD; i++) begin
			diff = {1'b0, cur_slot} - {1'b0, geo_q.lag[i]};
			rd_slot[i] = diff[AW] ? AW'(diff + (AW+1)'(HIST)) : diff[AW-1:0];
		end
	end

	assign wr_en = item_acc && live;
	assign rd_en = item_acc && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			wslot_q <= '0;
		end else if (wr_en) begin
			pos_q   <= q + 1'b1;
			wslot_q <= next_slot;
		end
	end

	// Delay line, three copies with two read ports each
	logic [NRD-1:0][fnblur_pkg::PIX_W-1:0] rd_word_s1;

	for (genvar gi = 0; gi < NRD / 2; gi++) begin : g_copy
		logic [fnblur_pkg::PIX_W-1:0] mem [HIST];
		logic [fnblur_pkg::PIX_W-1:0] rd_a_s1;
		logic [fnblur_pkg::PIX_W-1:0] rd_b_s1;

		always_ff @(posedge clk) begin
			if (wr_en) begin
				mem[cur_slot] <= s_axis_tdata;
			end
			if (rd_en) begin
				rd_a_s1 <= mem[rd_slot[2*gi]];
				rd_b_s1 <= mem[rd_slot[2*gi+1]];
			end
		end

		assign rd_word_s1[2*gi]   = rd_a_s1;
		assign rd_word_s1[2*gi+1] = rd_b_s1;
	end

	// Read stage
	logic [fnblur_pkg::PIX_W-1:0]  word_s1;
	logic [NRD-1:0]                zero_s1;
	logic [NRD-1:0]                nz_s1;
	logic [1:0]                    r_s1;
	logic [fnblur_pkg::IDX_W-1:0]  p_s1;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			word_s1 <= s_axis_tdata;
			zero_s1 <= geo_q.zero;
			nz_s1   <= nz;
			r_s1    <= geo_q.r;
			p_s1    <= p;
		end
	end

	logic [2:0][fnblur_pkg::CHAN_W-1:0] avg;

	always_comb begin
		logic [NRD-1:0][fnblur_pkg::PIX_W-1:0] w_eff;
		logic [63:0]                           lo_cat;
		logic [63:0]                           hi_cat;
		logic [63:0]                           sh_l;
		logic [63:0]                           sh_r;
		logic [2:0]                            sel_l;
		logic [2:0]                            sel_r;
		logic [9:0]                            sum;
		for (int i = 0; i < NRD; i++) begin
			if (!nz_s1[i]) begin
				w_eff[i] = '0;
			end else if (zero_s1[i]) begin
				w_eff[i] = word_s1;
			end else begin
				w_eff[i] = rd_word_s1[i];
			end
		end
		lo_cat = {w_eff[RD_L0], w_eff[RD_L1]};
		hi_cat = {w_eff[RD_R1], w_eff[RD_R0]};
		for (int c = 0; c < 3; c++) begin
			sel_l = 3'(c) + 3'd4 - {1'b0, r_s1};
			sel_r = 3'(c) + {1'b0, r_s1};
			sh_l  = lo_cat >> {sel_l, 3'b000};
			sh_r  = hi_cat >> {sel_r, 3'b000};
			sum   = {2'd0, w_eff[RD_UP][8*c +: 8]} + {2'd0, w_eff[RD_DN][8*c +: 8]}
				+ {2'd0, sh_l[7:0]} + {2'd0, sh_r[7:0]};
			avg[c] = sum[9:2];
		end
	end

	// Output register
	logic [fnblur_pkg::OUT_DATA_W-1:0] m_data_q;

	assign can_out       = !m_valid_q || m_axis_tready;
	assign s_axis_tready = !v_s1 || can_out;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				v_s1 <= 1'b1;
			end else if (can_out) begin
				v_s1 <= 1'b0;
			end
			if (can_out) begin
				m_valid_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_out && v_s1) begin
			m_data_q <= {2'b00, avg[2], avg[1], avg[0], p_s1};
		end
	end

	`FNB_ASSERT_HOLDS(a_wslot_range, 1'b1, int'(wslot_q) < HIST, "write slot out of range")
	`FNB_ASSERT_NEXT(a_emit_loads, rd_en, v_s1, "result item lost after read")
	`FNB_ASSERT_NEXT(a_pos_step, wr_en && !s_axis_tuser[0], pos_q == $past(pos_q) + 23'd1, "position did not advance")
	`FNB_ASSERT_NEXT(a_pos_stuck, item_acc && !live, pos_q == $past(pos_q), "position moved past limit")

endmodule
